// ===== hw/rtl/dsil_pkg.sv =====
// Shared types and codes for the descending sorted insertion list.
package dsil_pkg;

	localparam int ScoreW = 32;
	localparam int TagW   = 20;
	localparam int IndexW = 6;
	localparam int PosW   = 7;
	localparam int CountW = 7;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DROP  = 2'd1,
		ST_EVICT = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [ScoreW-1:0] score;
		logic [TagW-1:0]   tag;
		logic [IndexW-1:0] index;
	} item_t;

	typedef struct packed {
		logic [PosW-1:0]   position;
		logic [ScoreW-1:0] entry_score;
		logic [TagW-1:0]   entry_tag;
		logic [CountW-1:0] count;
		logic [1:0]        status;
	} result_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;
		logic [ScoreW-1:0] score;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/dsil_cell.sv =====
// One slot of the sorted chain: holds a pair, compares, shifts from its upper neighbor.
module dsil_cell import dsil_pkg::*; #(
	parameter int TAG_BITS = 20
) (
	input  logic                clk,
	input  cell_cmd_t           cmd,
	input  logic [TAG_BITS-1:0] new_tag,
	input  logic                valid,
	input  logic                prev_f,
	input  logic [ScoreW-1:0]   prev_score,
	input  logic [TAG_BITS-1:0] prev_tag,
	output logic                f,
	output logic [ScoreW-1:0]   score_q,
	output logic [TAG_BITS-1:0] tag_q
);

	// f: new pair lands at or above this slot
	assign f = !valid || ($signed(score_q) < $signed(cmd.score));

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_f) begin
				score_q <= prev_score;
				tag_q   <= prev_tag;
			end else if (f) begin
				score_q <= cmd.score;
				tag_q   <= new_tag;
			end
		end
	end

endmodule

// ===== hw/rtl/dsil_select.sv =====
// One-hot select over the chain: picks the hit slot's data and encodes its position.
module dsil_select #(
	parameter int N = 64,
	parameter int W = 52
) (
	input  logic [N-1:0]        hit,
	input  logic [N-1:0][W-1:0] data,
	output logic                any,
	output logic [$clog2(N)-1:0] idx,
	output logic [W-1:0]        sel
);

	localparam int IdxW = $clog2(N);

	always_comb begin
		any = 1'b0;
		idx = '0;
		sel = '0;
		for (int i = 0; i < N; i++) begin
			if (hit[i]) begin
				any = 1'b1;
				idx = idx | IdxW'(i);
				sel = sel | data[i];
			end
		end
	end

endmodule

// ===== hw/rtl/descending_sorted_insert_list.sv =====
// Top level of the descending sorted insertion list.
// Holds up to CAPACITY (score, tag) pairs, highest score in slot 0, in a chain of
// cells. An insert compares the new score in every cell at once and shifts the
// lower part of the chain down one slot in the cycle the beat is accepted, so one
// insert, read or clear is taken every cycle unless the result side stalls.
// Each result is registered in the chain stage, then in the select stage that picks
// the read slot and encodes the position. Equal scores keep arrival order; a full
// list evicts its last entry or drops a pair that ranks last.
module descending_sorted_insert_list import dsil_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 20
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CntW  = $clog2(CAPACITY + 1);
	localparam int IdxW  = $clog2(CAPACITY);
	localparam int DataW = ScoreW + TAG_BITS;

	logic [CntW-1:0]                count_q, count_d;
	logic [CAPACITY-1:0]            cell_f, cell_valid, prev_f, hit_d;
	logic [CAPACITY-1:0][ScoreW-1:0] cell_score;
	logic [CAPACITY-1:0][TAG_BITS-1:0] cell_tag;
	logic [CAPACITY-1:0][DataW-1:0] cell_data;
	logic [TAG_BITS-1:0]            new_tag;
	cell_cmd_t                      cmd;
	logic                           accept, out_free, full, drop, rd_ok;
	status_t                        status_d;

	logic                           s1_valid_q, out_valid_q;
	logic [CAPACITY-1:0]            hit_s1;
	logic [1:0]                     action_s1;
	logic [ScoreW-1:0]              score_s1;
	logic [TAG_BITS-1:0]            tag_s1;
	logic [CntW-1:0]                count_s1;
	status_t                        status_s1;

	logic                           sel_any;
	logic [IdxW-1:0]                sel_idx;
	logic [DataW-1:0]               sel_data;
	logic [CntW-1:0]                pos_sel;
	result_t                        res_d, res_q;

	assign out_free   = !out_valid_q || !result_stall;
	assign item_stall = s1_valid_q && !out_free;
	assign accept     = item_valid && !item_stall;

	assign new_tag   = TAG_BITS'(item.tag);
	assign cmd.ins   = accept && (item.action == ACT_INSERT);
	assign cmd.score = item.score;

	assign full  = (count_q == CntW'(CAPACITY));
	assign drop  = full && !cell_f[CAPACITY-1];
	assign rd_ok = (item.action == ACT_READ) && (32'(item.index) < 32'(count_q));

	assign prev_f[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_valid[i] = 32'(i) < 32'(count_q);
		if (i > 0) begin : g_prev
			assign prev_f[i] = cell_f[i-1];
		end
		dsil_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.new_tag   (new_tag),
			.valid     (cell_valid[i]),
			.prev_f    (prev_f[i]),
			.prev_score(cell_score[(i > 0) ? i - 1 : 0]),
			.prev_tag  (cell_tag[(i > 0) ? i - 1 : 0]),
			.f         (cell_f[i]),
			.score_q   (cell_score[i]),
			.tag_q     (cell_tag[i])
		);
		assign cell_data[i] = {cell_score[i], cell_tag[i]};
		assign hit_d[i] = (item.action == ACT_INSERT) ? (cell_f[i] && !prev_f[i])
			: (rd_ok && (32'(item.index) == 32'(i)));
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		case (item.action)
			ACT_INSERT: begin
				if (drop) begin
					status_d = ST_DROP;
				end else if (full) begin
					status_d = ST_EVICT;
				end else begin
					count_d = count_q + CntW'(1);
				end
			end
			ACT_READ: begin
				status_d = rd_ok ? ST_OK : ST_BAD;
			end
			ACT_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			s1_valid_q <= accept || (s1_valid_q && !out_free);
			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1    <= hit_d;
			action_s1 <= item.action;
			score_s1  <= item.score;
			tag_s1    <= new_tag;
			count_s1  <= count_d;
			status_s1 <= status_d;
		end
		if (s1_valid_q && out_free) begin
			res_q <= res_d;
		end
	end

	dsil_select #(
		.N(CAPACITY),
		.W(DataW)
	) u_select (
		.hit (hit_s1),
		.data(cell_data),
		.any (sel_any),
		.idx (sel_idx),
		.sel (sel_data)
	);

	assign pos_sel = sel_any ? CntW'(sel_idx) : CntW'(CAPACITY);

	always_comb begin
		res_d.position    = PosW'(pos_sel);
		res_d.entry_score = '0;
		res_d.entry_tag   = '0;
		res_d.count       = CountW'(count_s1);
		res_d.status      = status_s1;
		case (action_s1)
			ACT_INSERT: begin
				res_d.entry_score = score_s1;
				res_d.entry_tag   = TagW'(tag_s1);
			end
			ACT_READ: begin
				if (sel_any) begin
					res_d.entry_score = sel_data[DataW-1 -: ScoreW];
					res_d.entry_tag   = TagW'(sel_data[TAG_BITS-1:0]);
				end
			end
			ACT_CLEAR: begin
				res_d.position = '0;
			end
			default: begin
				res_d.position = PosW'(CntW'(CAPACITY));
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = res_q;

endmodule

// ===== hw/rtl/dsil_checker.sv =====
// Port-level checks for the sorted insertion list, bound to the top level.
module dsil_checker import dsil_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	localparam logic [PosW-1:0]   CapPos = PosW'(CAPACITY);
	localparam logic [CountW-1:0] CapCnt = CountW'(CAPACITY);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_BAD) |->
			(result.position == CapPos) && (result.entry_score == '0)
			&& (result.entry_tag == '0))
		else $error("invalid request returned data");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((result.status == ST_DROP) || (result.status == ST_EVICT)) |->
			(result.count == CapCnt))
		else $error("drop or eviction on a list that is not full");

	a_drop_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_DROP) |-> (result.position == CapPos))
		else $error("dropped pair reported a slot");

endmodule

bind descending_sorted_insert_list dsil_checker #(
	.CAPACITY(CAPACITY)
) u_dsil_checker (.*);
